// ===== rtl/tfm_pkg.sv =====
// ----------------------------------------------------------------------------
// tfm_pkg
// Shared types and constants for the two-channel reciprocal frequency meter.
// ----------------------------------------------------------------------------
package tfm_pkg;

	// Channel count default and state widths
	localparam int NUM_CHANNELS_DEF = 2;
	localparam int CNT_W            = 16;
	localparam int CLK_W            = 32;
	localparam int WEIGHT_W         = 17;

	// Divider operand widths: dividend is 2*clock + period, divisor is 2*period
	localparam int DIVIDEND_W = CLK_W + 2;
	localparam int DIVISOR_W  = CLK_W + 1;
	localparam int DIV_STEPS  = DIVIDEND_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	// Register reset values
	localparam logic [CLK_W-1:0]    CLOCK_RATE_RST      = 32'd72000000;
	localparam logic [WEIGHT_W-1:0] OVERFLOW_WEIGHT_RST = 17'd65536;

	// Configuration register indexes
	localparam int                  CFG_IDX_W           = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_RATE      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_OVERFLOW_WEIGHT = 1'b1;

	// Input commands
	localparam logic CMD_WRAP    = 1'b0;
	localparam logic CMD_CAPTURE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_CHK,
		ST_DIV,
		ST_DONE
	} fsm_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/two_channel_frequency_meter.sv =====
// ----------------------------------------------------------------------------
// two_channel_frequency_meter
// Reciprocal frequency meter: per-channel edge pairs on a shared 16-bit
// counter give a period in ticks and a rounded frequency in hertz.
// ----------------------------------------------------------------------------
// A wrap item or a first edge is taken in the idle state and gives no result.
// The edge that closes a pair runs multiply, add, check, 34 divider steps and
// hand-off to a valid result; a zero period skips the divider.
// While idle, one item per cycle for wraps and first edges; a measurement
// holds off new items until its hand-off is done, also while the output stalls.
// Reset: arst_n clears all channel state and restores the register defaults.
// ----------------------------------------------------------------------------
module two_channel_frequency_meter #(
	parameter int NUM_CHANNELS = tfm_pkg::NUM_CHANNELS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [tfm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tfm_pkg::CLK_W-1:0]          cfg_data,
	// input items
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               command,
	input  logic                               channel,
	input  logic [tfm_pkg::CNT_W-1:0]          capture_value,
	// result items
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               result_channel,
	output logic [tfm_pkg::CLK_W-1:0]          period_ticks,
	output logic [tfm_pkg::CLK_W-1:0]          frequency_hz,
	output logic                               zero_period
);

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	// Configuration registers
	logic [tfm_pkg::CLK_W-1:0]    clock_rate_q;
	logic [tfm_pkg::WEIGHT_W-1:0] weight_q;

	// Per-channel state
	logic [NUM_CHANNELS-1:0]      armed_q;
	logic [tfm_pkg::CNT_W-1:0]    first_q [NUM_CHANNELS];
	logic [tfm_pkg::CNT_W-1:0]    wrap_q  [NUM_CHANNELS];

	// Measurement working registers
	logic                         ch_q;
	logic [tfm_pkg::CNT_W-1:0]    cap_q;
	logic [tfm_pkg::CNT_W-1:0]    first_sel_q;
	logic [tfm_pkg::CNT_W-1:0]    wrap_sel_q;
	logic [tfm_pkg::CLK_W-1:0]    prod_q;
	logic [tfm_pkg::CLK_W-1:0]    period_q;
	logic                         zero_q;

	// Output register
	logic                         out_valid_q;
	logic                         res_ch_q;
	logic [tfm_pkg::CLK_W-1:0]    res_period_q;
	logic [tfm_pkg::CLK_W-1:0]    res_freq_q;
	logic                         res_zero_q;

	tfm_pkg::fsm_state_t          state_q;
	tfm_pkg::fsm_state_t          state_d;

	logic [CH_W-1:0]              ch_idx;
	logic                         ch_ok;
	logic                         in_xfer;
	logic                         wrap_evt;
	logic                         cap_evt;
	logic                         second_evt;
	logic                         div_start;
	logic                         out_load;
	logic [tfm_pkg::CLK_W:0]      mul_full;
	logic [tfm_pkg::CLK_W-1:0]    period_d;
	logic [tfm_pkg::DIVIDEND_W-1:0] div_num;
	logic [tfm_pkg::DIVISOR_W-1:0]  div_den;
	logic [tfm_pkg::DIVIDEND_W-1:0] div_quo;
	tfm_pkg::div_stat_t           div_stat;

	// ------------------------------------------------------------------
	// Configuration: always ready; the sender writes only while no item
	// is in flight
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_rate_q <= tfm_pkg::CLOCK_RATE_RST;
			weight_q     <= tfm_pkg::OVERFLOW_WEIGHT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				tfm_pkg::CFG_CLOCK_RATE:      clock_rate_q <= cfg_data;
				tfm_pkg::CFG_OVERFLOW_WEIGHT: weight_q     <= cfg_data[tfm_pkg::WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input decode
	// ------------------------------------------------------------------
	// Captures on channels beyond the configured count are dropped.
	assign ch_idx     = CH_W'(channel);
	assign ch_ok      = 32'(channel) < 32'(NUM_CHANNELS);
	assign in_xfer    = in_valid && in_ready;
	assign wrap_evt   = in_xfer && (command == tfm_pkg::CMD_WRAP);
	assign cap_evt    = in_xfer && (command == tfm_pkg::CMD_CAPTURE) && ch_ok;
	assign second_evt = cap_evt && armed_q[ch_idx];

	// ------------------------------------------------------------------
	// Channel state: wraps bump every count, any accepted edge on a channel
	// clears its count, edges alternate between first and second.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				first_q[i] <= '0;
				wrap_q[i]  <= '0;
			end
		end else begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				if (wrap_evt) begin
					wrap_q[i] <= wrap_q[i] + 1'b1;
				end else if (cap_evt && (ch_idx == CH_W'(i))) begin
					wrap_q[i]  <= '0;
					armed_q[i] <= !armed_q[i];
					if (!armed_q[i]) begin
						first_q[i] <= capture_value;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Measurement datapath
	// ------------------------------------------------------------------
	// Snapshot the operands of the edge that closes a pair
	always_ff @(posedge clk) begin
		if (second_evt) begin
			ch_q        <= channel;
			cap_q       <= capture_value;
			first_sel_q <= first_q[ch_idx];
			wrap_sel_q  <= wrap_q[ch_idx];
		end
	end

	// Ticks from wraps, then period modulo 2^32
	assign mul_full = weight_q * wrap_sel_q;
	assign period_d = prod_q + tfm_pkg::CLK_W'(cap_q) - tfm_pkg::CLK_W'(first_sel_q);

	always_ff @(posedge clk) begin
		if (state_q == tfm_pkg::ST_MUL) begin
			prod_q <= mul_full[tfm_pkg::CLK_W-1:0];
		end
		if (state_q == tfm_pkg::ST_ADD) begin
			period_q <= period_d;
		end
		if (state_q == tfm_pkg::ST_CHK) begin
			zero_q <= (period_q == '0);
		end
	end

	// Round half up: (2*clock + period) / (2*period)
	assign div_num = {1'b0, clock_rate_q, 1'b0} + {2'b00, period_q};
	assign div_den = {period_q, 1'b0};

	tfm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tfm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tfm_pkg::ST_IDLE: begin
				if (second_evt) begin
					state_d = tfm_pkg::ST_MUL;
				end
			end
			tfm_pkg::ST_MUL:  state_d = tfm_pkg::ST_ADD;
			tfm_pkg::ST_ADD:  state_d = tfm_pkg::ST_CHK;
			tfm_pkg::ST_CHK: begin
				// Zero period skips the divider
				state_d = (period_q == '0) ? tfm_pkg::ST_DONE : tfm_pkg::ST_DIV;
			end
			tfm_pkg::ST_DIV: begin
				if (div_stat.done) begin
					state_d = tfm_pkg::ST_DONE;
				end
			end
			tfm_pkg::ST_DONE: begin
				// Hold until the output register is free
				if (!out_valid_q || out_ready) begin
					state_d = tfm_pkg::ST_IDLE;
				end
			end
			default: state_d = tfm_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			tfm_pkg::ST_IDLE: in_ready  = 1'b1;
			tfm_pkg::ST_CHK:  div_start = (period_q != '0);
			tfm_pkg::ST_DONE: out_load  = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// Output register: parts the sequencer from the downstream stall
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_ch_q     <= ch_q;
			res_period_q <= period_q;
			res_freq_q   <= zero_q ? '0 : div_quo[tfm_pkg::CLK_W-1:0];
			res_zero_q   <= zero_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_channel = res_ch_q;
	assign period_ticks   = res_period_q;
	assign frequency_hz   = res_freq_q;
	assign zero_period    = res_zero_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	// The divider never starts on a zero period
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (period_q != '0))
		else $error("divider started on zero period");

	// Items are taken only while the shared divider is free
	a_in_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> !div_stat.busy)
		else $error("input transfer while divider busy");

	// A new result appears only from the hand-off state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == tfm_pkg::ST_DONE))
		else $error("result loaded outside hand-off");

	// A flagged zero period carries frequency zero
	a_zero_freq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_zero_q) |-> (res_freq_q == '0))
		else $error("zero period with nonzero frequency");

endmodule

// ===== rtl/tfm_div.sv =====
// ----------------------------------------------------------------------------
// tfm_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module tfm_div (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [tfm_pkg::DIVIDEND_W-1:0]       dividend,
	input  logic [tfm_pkg::DIVISOR_W-1:0]        divisor,
	output tfm_pkg::div_stat_t                   stat,
	output logic [tfm_pkg::DIVIDEND_W-1:0]       quotient
);

	logic                              busy_q;
	logic [tfm_pkg::STEP_W-1:0]        cnt_q;
	logic [tfm_pkg::DIVISOR_W-1:0]     rem_q;
	logic [tfm_pkg::DIVISOR_W-1:0]     den_q;
	logic [tfm_pkg::DIVIDEND_W-1:0]    quo_q;

	logic [tfm_pkg::DIVISOR_W:0]       trial;
	logic [tfm_pkg::DIVISOR_W:0]       diff;
	logic                              fits;
	logic                              last_step;

	// Bring down the next dividend bit and try the subtraction
	assign trial     = {rem_q, quo_q[tfm_pkg::DIVIDEND_W-1]};
	assign diff      = trial - {1'b0, den_q};
	assign fits      = trial >= {1'b0, den_q};
	assign last_step = busy_q && (cnt_q == tfm_pkg::STEP_W'(tfm_pkg::DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (last_step) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[tfm_pkg::DIVISOR_W-1:0] : trial[tfm_pkg::DIVISOR_W-1:0];
			quo_q <= {quo_q[tfm_pkg::DIVIDEND_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = last_step;
	assign quotient  = quo_q;

endmodule

// ===== tb/tb_two_channel_frequency_meter.sv =====
// ----------------------------------------------------------------------------
// tb_two_channel_frequency_meter
// Self-checking bench for the two-channel reciprocal frequency meter. A
// scoreboard model tracks edge pairs and wrap counts per channel, predicts
// period and rounded frequency for every edge that closes a pair, and compares
// each result transfer field by field. Directed edge cases, register extremes, a
// long run of wraps and randomized traffic under several flow-control
// mixes are run in turn.
// ----------------------------------------------------------------------------
module tb_two_channel_frequency_meter;

	// Wait after the last result before touching registers: covers the
	// measurement path plus the wrap and first-edge path.
	localparam int SETTLE_CYCLES = 50;
	// Run limit in time units (2 units per clock).
	localparam int RUN_LIMIT = 1_600_000;

	typedef struct {
		logic                      chan;
		logic [tfm_pkg::CLK_W-1:0] period;
		logic [tfm_pkg::CLK_W-1:0] freq;
		logic                      zero;
	} measurement_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_valid;
	logic                          cfg_ready;
	logic [tfm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tfm_pkg::CLK_W-1:0]     cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic                          command;
	logic                          channel;
	logic [tfm_pkg::CNT_W-1:0]     capture_value;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic                          result_channel;
	logic [tfm_pkg::CLK_W-1:0]     period_ticks;
	logic [tfm_pkg::CLK_W-1:0]     frequency_hz;
	logic                          zero_period;

	// Scoreboard copy of the meter: registers and per-channel edge state
	logic [tfm_pkg::CLK_W-1:0]    clock_rate_mdl;
	logic [tfm_pkg::WEIGHT_W-1:0] weight_mdl;
	logic                         armed_mdl [2];
	logic [tfm_pkg::CNT_W-1:0]    first_edge_mdl [2];
	logic [tfm_pkg::CNT_W-1:0]    wraps_mdl [2];

	measurement_t pending_measurements [$];
	int           mismatch_count = 0;
	int           send_idle_pct = 0;
	int           stall_pct = 0;

	two_channel_frequency_meter dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.command        (command),
		.channel        (channel),
		.capture_value  (capture_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result_channel (result_channel),
		.period_ticks   (period_ticks),
		.frequency_hz   (frequency_hz),
		.zero_period    (zero_period)
	);

	always #1 clk = ~clk;

	// Print one line per mismatch and count it.
	task automatic flag_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatch_count++;
	endtask

	// Reset the scoreboard state to the block's reset values.
	task automatic clear_meter_model();
		clock_rate_mdl = tfm_pkg::CLOCK_RATE_RST;
		weight_mdl     = tfm_pkg::OVERFLOW_WEIGHT_RST;
		for (int i = 0; i < 2; i++) begin
			armed_mdl[i]      = 1'b0;
			first_edge_mdl[i] = '0;
			wraps_mdl[i]      = '0;
		end
	endtask

	// Advance the model by one accepted item; queue a measurement as a pair closes.
	task automatic predict_measurement(input logic cmd, input logic ch,
			input logic [tfm_pkg::CNT_W-1:0] cap);
		measurement_t              m;
		logic [tfm_pkg::CLK_W-1:0] per;
		logic [tfm_pkg::CLK_W-1:0] wt32;
		logic [tfm_pkg::CLK_W-1:0] wr32;
		logic [63:0]               num;
		logic [63:0]               den;
		if (cmd == tfm_pkg::CMD_WRAP) begin
			// every channel's wrap count advances, modulo 2^16
			for (int i = 0; i < 2; i++)
				wraps_mdl[i] = wraps_mdl[i] + 1'b1;
			return;
		end
		if (!armed_mdl[ch]) begin
			first_edge_mdl[ch] = cap;
			wraps_mdl[ch]      = '0;
			armed_mdl[ch]      = 1'b1;
			return;
		end
		wt32 = {{(tfm_pkg::CLK_W-tfm_pkg::WEIGHT_W){1'b0}}, weight_mdl};
		wr32 = {{(tfm_pkg::CLK_W-tfm_pkg::CNT_W){1'b0}}, wraps_mdl[ch]};
		// all terms are 32 bits wide, so the sum wraps modulo 2^32
		per = wt32 * wr32 + {16'd0, cap} - {16'd0, first_edge_mdl[ch]};
		armed_mdl[ch] = 1'b0;
		wraps_mdl[ch] = '0;
		m.chan   = ch;
		m.period = per;
		if (per == '0) begin
			m.freq = '0;
			m.zero = 1'b1;
		end else begin
			// round half up: (2*clock + period) / (2*period)
			num    = {31'd0, clock_rate_mdl, 1'b0} + {32'd0, per};
			den    = {31'd0, per, 1'b0};
			m.freq = num / den;
			m.zero = 1'b0;
		end
		pending_measurements.push_back(m);
	endtask

	// Offer one item after an optional random gap and hold it until the transfer.
	task automatic send_item(input logic cmd, input logic ch,
			input logic [tfm_pkg::CNT_W-1:0] cap);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		command       <= cmd;
		channel       <= ch;
		capture_value <= cap;
		do @(posedge clk); while (!in_ready);
		predict_measurement(cmd, ch, cap);
	endtask

	task automatic send_edge(input logic ch, input logic [tfm_pkg::CNT_W-1:0] cap);
		send_item(tfm_pkg::CMD_CAPTURE, ch, cap);
	endtask

	// Wrap items carry random channel and capture fields; the block ignores them.
	task automatic send_wrap();
		send_item(tfm_pkg::CMD_WRAP, 1'($urandom), 16'($urandom));
	endtask

	// Drop valid and hold until every expected measurement has come back.
	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_measurements.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; valid drops for a cycle after each transfer.
	task automatic write_register(input logic [tfm_pkg::CFG_IDX_W-1:0] idx,
			input logic [tfm_pkg::CLK_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == tfm_pkg::CFG_CLOCK_RATE)
			clock_rate_mdl = data;
		else
			weight_mdl = data[tfm_pkg::WEIGHT_W-1:0];
		@(posedge clk);
	endtask

	// Write both registers; bits above the weight field carry random junk.
	task automatic set_registers(input logic [tfm_pkg::CLK_W-1:0] clk_rate,
			input logic [tfm_pkg::WEIGHT_W-1:0] wt);
		write_register(tfm_pkg::CFG_CLOCK_RATE, clk_rate);
		write_register(tfm_pkg::CFG_OVERFLOW_WEIGHT,
			($urandom & ~{{(tfm_pkg::CLK_W-tfm_pkg::WEIGHT_W){1'b0}},
				{tfm_pkg::WEIGHT_W{1'b1}}}) | {15'd0, wt});
	endtask

	// Result side: check each transfer, then pick the next ready at random.
	always @(posedge clk) begin
		measurement_t m;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready) begin
			if (pending_measurements.size() == 0) begin
				flag_mismatch($sformatf("unexpected result ch=%0d period=%0h",
					result_channel, period_ticks));
			end else begin
				m = pending_measurements.pop_front();
				if (result_channel !== m.chan)
					flag_mismatch($sformatf("result_channel %0d, want %0d",
						result_channel, m.chan));
				if (period_ticks !== m.period)
					flag_mismatch($sformatf("period_ticks %0h, want %0h",
						period_ticks, m.period));
				if (frequency_hz !== m.freq)
					flag_mismatch($sformatf("frequency_hz %0d, want %0d (period %0h)",
						frequency_hz, m.freq, m.period));
				if (zero_period !== m.zero)
					flag_mismatch($sformatf("zero_period %0d, want %0d",
						zero_period, m.zero));
			end
		end
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Edge cases at the reset register values.
	task automatic test_directed_edges();
		// zero period: the closing edge equals the first with no wraps
		send_edge(1'b0, 16'h0000);
		send_edge(1'b0, 16'h0000);
		// one wrap between edges, second value just below first
		send_edge(1'b1, 16'hFFFF);
		send_wrap();
		send_edge(1'b1, 16'hFFFE);
		// second below first with no wrap: period wraps modulo 2^32
		send_edge(1'b0, 16'hFFFF);
		send_edge(1'b0, 16'h0000);
		// one-tick period gives the full clock rate
		send_edge(1'b0, 16'h0000);
		send_edge(1'b0, 16'h0001);
		// interleave both channels around shared wraps
		send_edge(1'b0, 16'd100);
		send_edge(1'b1, 16'd200);
		send_wrap();
		send_wrap();
		send_edge(1'b1, 16'd150);
		send_edge(1'b0, 16'd300);
		// hold the sender until everything is back, then close a pair
		send_edge(1'b1, 16'h8000);
		wait_drain();
		send_edge(1'b1, 16'h7FFF);
		wait_drain();
	endtask

	// Register extremes, rounding ties and out-of-range values.
	task automatic test_register_extremes();
		logic [tfm_pkg::CLK_W-1:0]    rates [6];
		logic [tfm_pkg::WEIGHT_W-1:0] weights [6];
		rates   = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd3, 32'hFFFF_FFFF,
			tfm_pkg::CLOCK_RATE_RST};
		weights = '{17'd0, 17'd65536, 17'd1, 17'd2, 17'h1FFFF,
			tfm_pkg::OVERFLOW_WEIGHT_RST};
		for (int s = 0; s < 6; s++) begin
			set_registers(rates[s], weights[s]);
			// period equals the weight; zero when the weight is zero
			send_edge(1'b0, 16'd7);
			send_wrap();
			send_edge(1'b0, 16'd7);
			// period of one tick
			send_edge(1'b1, 16'd0);
			send_edge(1'b1, 16'd1);
			// period 6: a tie when the clock rate is 3
			send_edge(1'b0, 16'd0);
			send_edge(1'b0, 16'd6);
			// two wraps: period is twice the weight
			send_edge(1'b1, 16'd5);
			send_wrap();
			send_wrap();
			send_edge(1'b1, 16'd5);
			// negative difference wraps modulo 2^32
			send_edge(1'b0, 16'd10);
			send_edge(1'b0, 16'd8);
			wait_drain();
		end
	endtask

	// Build up a large wrap count on both channels, then close each pair.
	task automatic test_long_wrap_run();
		send_idle_pct = 0;
		stall_pct     = 0;
		send_edge(1'b0, 16'h1234);
		send_edge(1'b1, 16'h0000);
		repeat (100) send_wrap();
		// channel 1 closes with the long wrap count
		send_edge(1'b1, 16'hFFFF);
		// one more wrap for channel 0
		send_wrap();
		send_edge(1'b0, 16'h1235);
		wait_drain();
	endtask

	// Pick a capture value: near the armed first edge, an extreme, or random.
	function automatic logic [tfm_pkg::CNT_W-1:0] pick_capture(input logic ch);
		logic [tfm_pkg::CNT_W-1:0] base;
		base = first_edge_mdl[ch];
		if (!armed_mdl[ch])
			return ($urandom_range(3) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'h0000)
				: 16'($urandom);
		case ($urandom_range(3))
			0: return base + 16'($urandom_range(3));
			1: return base - 16'($urandom_range(3));
			2: return $urandom_range(1) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom);
		endcase
	endfunction

	// Random edge pairs with wraps mixed in, under one flow-control mix.
	task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n);
		int r;
		logic ch;
		logic [tfm_pkg::CLK_W-1:0] rate;
		wait_drain();
		rate = ($urandom_range(3) == 0) ? 32'($urandom_range(1, 1000)) : 32'($urandom);
		if (rate == '0)
			rate = 32'd1;
		set_registers(rate, 17'($urandom_range(1, 65536)));
		send_idle_pct = send_pct;
		stall_pct     = recv_pct;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 1) begin
				// burst of wraps to give large wrap counts
				repeat ($urandom_range(10, 60)) send_wrap();
			end else if (r < 21) begin
				send_wrap();
			end else begin
				ch = 1'($urandom);
				send_edge(ch, pick_capture(ch));
			end
			if ($urandom_range(199) == 0)
				wait_drain();
		end
		wait_drain();
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= tfm_pkg::CFG_CLOCK_RATE;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		command       <= tfm_pkg::CMD_WRAP;
		channel       <= 1'b0;
		capture_value <= '0;
		clear_meter_model();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed_edges();
		send_idle_pct = 17;
		stall_pct     = 17;
		test_register_extremes();
		test_long_wrap_run();
		test_random_traffic(0, 0, 220);
		test_random_traffic(63, 0, 220);
		test_random_traffic(0, 63, 220);
		test_random_traffic(17, 17, 220);

		wait_drain();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#(RUN_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/tfm_pkg.sv
rtl/tfm_div.sv
rtl/two_channel_frequency_meter.sv
tb/tb_two_channel_frequency_meter.sv
